// File: sv/bkbc_pkg.sv
package bkbc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    K_NONE    = 3'd0,
    K_PAREN   = 3'd1,
    K_SQUARE  = 3'd2,
    K_CURLY   = 3'd3,
    K_BEGIN   = 3'd4,
    K_COMMENT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    KW_IDLE      = 3'd0,
    KW_BEGIN     = 3'd1,
    KW_END       = 3'd2,
    KW_CMT_OPEN  = 3'd3,
    KW_CMT_CLOSE = 3'd4
  } kw_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNBAL     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQ    = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LCURLY = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURLY = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LO_D   = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;
  localparam logic [CHAR_W-1:0] CH_LO_G   = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LO_I   = 8'h69;
  localparam logic [CHAR_W-1:0] CH_LO_N   = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

  // fold upper-case letters to lower case
  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

  // letters expected after the leading b of begin
  function automatic logic [CHAR_W-1:0] begin_tail(input logic [1:0] pos);
    logic [CHAR_W-1:0] r;
    case (pos)
      2'd0:    r = CH_LO_E;
      2'd1:    r = CH_LO_G;
      2'd2:    r = CH_LO_I;
      default: r = CH_LO_N;
    endcase
    return r;
  endfunction

endpackage

// File: sv/bkbc_ram.sv
module bkbc_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/bracket_keyword_balance_checker_top.sv
// Channel  Dir  Bus                           Contents (low bit up)
// s_*      in   tvalid/tready/tdata/tlast     tdata[7:0] char_in; tlast = last
// m_*      out  tvalid/tready/tdata           status[2:0] leftover_kind[5:3]
//                                             open_count[12:6], zero fill to 16
//
// One byte per cycle, back to back; a result is presented in the cycle after the
// transfer of the byte marked last. The top of stack lives in a register and
// the entry below it is prefetched from the stack RAM every cycle, so a pop
// never waits on the registered RAM read. Reset (rst, synchronous) clears the
// control state; stack RAM contents are never cleared and need no sweep.
// Input stalls only while an undelivered result sits in the output register
// and m_tready is low.
module bracket_keyword_balance_checker_top #(
  parameter int unsigned STACK_DEPTH = bkbc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [5:3] leftover_kind, [12:6] open_count
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
  localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

  // architectural state
  logic [DW-1:0]            stack_depth, stack_depth_next;
  bkbc_pkg::kind_t          top_kind, top_kind_next;
  bkbc_pkg::kw_t            keyword_kind, keyword_kind_next;
  logic [1:0]               keyword_pos, keyword_pos_next;
  logic                     mismatch_seen, mismatch_seen_next;
  bkbc_pkg::status_t        error_code, error_code_next;

  // prefetch of the entry below the top, with write forwarding
  logic                     fwd_hit, fwd_hit_next;
  logic [bkbc_pkg::KIND_W-1:0] fwd_data;
  logic [bkbc_pkg::KIND_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;
  bkbc_pkg::kind_t          below_kind;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [bkbc_pkg::KIND_W-1:0] wr_data;

  // output register
  logic                     out_valid;
  bkbc_pkg::status_t        out_status, out_status_next;
  bkbc_pkg::kind_t          out_kind, out_kind_next;
  logic [bkbc_pkg::COUNT_W-1:0] out_count, out_count_next;

  logic                     accept;
  logic [7:0]               ch, lc;

  // per-byte working values before the end-of-text clear
  logic                     do_push, do_close;
  bkbc_pkg::kind_t          push_kind, close_kind;
  logic [DW-1:0]            depth_upd;
  bkbc_pkg::kind_t          top_upd;
  bkbc_pkg::kw_t            kw_upd;
  logic [1:0]               pos_upd;
  logic                     mis_upd;
  bkbc_pkg::status_t        err_upd;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign ch       = s_tdata;
  assign lc       = bkbc_pkg::to_lower(s_tdata);

  assign below_kind = bkbc_pkg::kind_t'(fwd_hit ? fwd_data : rd_data);

  // decode one byte: keyword step or plain byte
  always_comb begin
    do_push    = 1'b0;
    do_close   = 1'b0;
    push_kind  = bkbc_pkg::K_NONE;
    close_kind = bkbc_pkg::K_NONE;
    kw_upd     = keyword_kind;
    pos_upd    = keyword_pos;
    err_upd    = error_code;
    if (error_code == bkbc_pkg::ST_OK) begin
      case (keyword_kind)
        bkbc_pkg::KW_BEGIN: begin
          if (lc == bkbc_pkg::begin_tail(keyword_pos)) begin
            if (keyword_pos == 2'd3) begin
              kw_upd    = bkbc_pkg::KW_IDLE;
              pos_upd   = 2'd0;
              do_push   = 1'b1;
              push_kind = bkbc_pkg::K_BEGIN;
            end else begin
              pos_upd = keyword_pos + 2'd1;
            end
          end else begin
            err_upd = bkbc_pkg::ST_MALFORMED;
          end
        end
        bkbc_pkg::KW_END: begin
          if (keyword_pos == 2'd0 && lc == bkbc_pkg::CH_LO_N) begin
            pos_upd = 2'd1;
          end else if (keyword_pos == 2'd1 && lc == bkbc_pkg::CH_LO_D) begin
            kw_upd     = bkbc_pkg::KW_IDLE;
            pos_upd    = 2'd0;
            do_close   = 1'b1;
            close_kind = bkbc_pkg::K_BEGIN;
          end else begin
            err_upd = bkbc_pkg::ST_MALFORMED;
          end
        end
        bkbc_pkg::KW_CMT_OPEN: begin
          if (ch == bkbc_pkg::CH_STAR) begin
            kw_upd    = bkbc_pkg::KW_IDLE;
            do_push   = 1'b1;
            push_kind = bkbc_pkg::K_COMMENT;
          end else begin
            err_upd = bkbc_pkg::ST_MALFORMED;
          end
        end
        bkbc_pkg::KW_CMT_CLOSE: begin
          if (ch == bkbc_pkg::CH_SLASH) begin
            kw_upd     = bkbc_pkg::KW_IDLE;
            do_close   = 1'b1;
            close_kind = bkbc_pkg::K_COMMENT;
          end else begin
            err_upd = bkbc_pkg::ST_MALFORMED;
          end
        end
        bkbc_pkg::KW_IDLE: begin
          pos_upd = 2'd0;
          if (lc == bkbc_pkg::CH_LO_B) begin
            kw_upd = bkbc_pkg::KW_BEGIN;
          end else if (lc == bkbc_pkg::CH_LO_E) begin
            kw_upd = bkbc_pkg::KW_END;
          end else if (ch == bkbc_pkg::CH_SLASH) begin
            kw_upd = bkbc_pkg::KW_CMT_OPEN;
          end else if (ch == bkbc_pkg::CH_STAR) begin
            kw_upd = bkbc_pkg::KW_CMT_CLOSE;
          end else if (ch == bkbc_pkg::CH_LPAREN) begin
            do_push = 1'b1; push_kind = bkbc_pkg::K_PAREN;
          end else if (ch == bkbc_pkg::CH_LSQ) begin
            do_push = 1'b1; push_kind = bkbc_pkg::K_SQUARE;
          end else if (ch == bkbc_pkg::CH_LCURLY) begin
            do_push = 1'b1; push_kind = bkbc_pkg::K_CURLY;
          end else if (ch == bkbc_pkg::CH_RPAREN) begin
            do_close = 1'b1; close_kind = bkbc_pkg::K_PAREN;
          end else if (ch == bkbc_pkg::CH_RSQ) begin
            do_close = 1'b1; close_kind = bkbc_pkg::K_SQUARE;
          end else if (ch == bkbc_pkg::CH_RCURLY) begin
            do_close = 1'b1; close_kind = bkbc_pkg::K_CURLY;
          end else begin
            err_upd = bkbc_pkg::ST_INVALID;
          end
        end
        default: begin
          err_upd = bkbc_pkg::ST_MALFORMED;
        end
      endcase
    end
  end

  // stack update: top in a register, older entries in the RAM
  always_comb begin
    depth_upd = stack_depth;
    top_upd   = top_kind;
    mis_upd   = mismatch_seen;
    wr_en     = 1'b0;
    wr_addr   = AW'(stack_depth - DEPTH_ONE);
    wr_data   = top_kind;
    if (do_push) begin
      // a full stack holds its contents; the overflow code is set below
      if (stack_depth != DEPTH_FULL) begin
        // spill the current top below the new one
        wr_en     = accept && (stack_depth != '0);
        top_upd   = push_kind;
        depth_upd = stack_depth + DEPTH_ONE;
      end
    end else if (do_close) begin
      if (stack_depth != '0 && top_kind == close_kind) begin
        top_upd   = below_kind;
        depth_upd = stack_depth - DEPTH_ONE;
      end else begin
        mis_upd = 1'b1;
      end
    end
  end

  // next state, result capture and clear at end of text
  always_comb begin
    stack_depth_next   = stack_depth;
    top_kind_next      = top_kind;
    keyword_kind_next  = keyword_kind;
    keyword_pos_next   = keyword_pos;
    mismatch_seen_next = mismatch_seen;
    error_code_next    = error_code;
    out_status_next    = out_status;
    out_kind_next      = out_kind;
    out_count_next     = out_count;
    if (accept) begin
      stack_depth_next   = depth_upd;
      top_kind_next      = top_upd;
      keyword_kind_next  = kw_upd;
      keyword_pos_next   = pos_upd;
      mismatch_seen_next = mis_upd;
      error_code_next    = (do_push && stack_depth == DEPTH_FULL) ?
                           bkbc_pkg::ST_OVERFLOW : err_upd;
      if (s_tlast) begin
        if (error_code_next != bkbc_pkg::ST_OK) begin
          out_status_next = error_code_next;
        end else if (kw_upd != bkbc_pkg::KW_IDLE) begin
          out_status_next = bkbc_pkg::ST_MALFORMED;
        end else if (mis_upd || depth_upd != '0) begin
          out_status_next = bkbc_pkg::ST_UNBAL;
        end else begin
          out_status_next = bkbc_pkg::ST_OK;
        end
        out_kind_next  = (depth_upd != '0) ? top_upd : bkbc_pkg::K_NONE;
        out_count_next = (32'(depth_upd) > 32'(bkbc_pkg::COUNT_MAX)) ?
                         bkbc_pkg::COUNT_MAX : bkbc_pkg::COUNT_W'(depth_upd);
        // clear for the next text
        stack_depth_next   = '0;
        top_kind_next      = bkbc_pkg::K_NONE;
        keyword_kind_next  = bkbc_pkg::KW_IDLE;
        keyword_pos_next   = 2'd0;
        mismatch_seen_next = 1'b0;
        error_code_next    = bkbc_pkg::ST_OK;
      end
    end
  end

  // prefetch the entry that will sit below the top next cycle; forward
  // the spill when it targets that same entry
  assign rd_addr      = AW'(stack_depth_next - DEPTH_TWO);
  assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

  bkbc_ram #(
    .WIDTH (bkbc_pkg::KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth   <= '0;
      top_kind      <= bkbc_pkg::K_NONE;
      keyword_kind  <= bkbc_pkg::KW_IDLE;
      keyword_pos   <= 2'd0;
      mismatch_seen <= 1'b0;
      error_code    <= bkbc_pkg::ST_OK;
      fwd_hit       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      stack_depth   <= stack_depth_next;
      top_kind      <= top_kind_next;
      keyword_kind  <= keyword_kind_next;
      keyword_pos   <= keyword_pos_next;
      mismatch_seen <= mismatch_seen_next;
      error_code    <= error_code_next;
      fwd_hit       <= fwd_hit_next;
      // hold the result until its transfer, load a fresh one on last
      if (accept && s_tlast) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data   <= wr_data;
    out_status <= out_status_next;
    out_kind   <= out_kind_next;
    out_count  <= out_count_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_count, out_kind, out_status};

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= DEPTH_FULL)
    else $error("stack depth above capacity");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> stack_depth == '0 && error_code == bkbc_pkg::ST_OK
                          && keyword_kind == bkbc_pkg::KW_IDLE && !mismatch_seen)
    else $error("state not cleared after end of text");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_code != bkbc_pkg::ST_OK && !(accept && s_tlast) |=>
      $stable(error_code) && $stable(stack_depth))
    else $error("state changed after an error");

  a_push_step: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast && do_push && stack_depth != DEPTH_FULL |=>
      stack_depth == $past(stack_depth) + DEPTH_ONE)
    else $error("push did not advance depth by one");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_status <= bkbc_pkg::ST_OVERFLOW
                 && out_kind <= bkbc_pkg::K_COMMENT)
    else $error("result field out of range");
`endif

endmodule
